/* design/thermal_throttle_level_tracker_macros.svh */
// Assertion macros shared by the thermal throttle level tracker.
`ifndef THERMAL_THROTTLE_LEVEL_TRACKER_MACROS_SVH
`define THERMAL_THROTTLE_LEVEL_TRACKER_MACROS_SVH

// Same-cycle implication, checked on clk, disabled while arst_n is low.
`define TTLT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("thermal throttle tracker: assertion failed");

// Next-cycle implication, checked on clk, disabled while arst_n is low.
`define TTLT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("thermal throttle tracker: assertion failed");

`endif

/* design/ttlt_pkg.sv */
// Shared types, constants and helper functions of the thermal throttle level tracker.
package ttlt_pkg;

	localparam int TEMP_W  = 18;
	localparam int LEVEL_W = 3;
	localparam int CNT_W   = 4;
	localparam int CAP_W   = 7;
	localparam int CFG_IDX_W = 4;

	typedef logic [TEMP_W-1:0]    temp_t;
	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CAP_W-1:0]     cap_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Throttle levels
	localparam level_t LVL_NORMAL   = 3'd0;
	localparam level_t LVL_WARM     = 3'd1;
	localparam level_t LVL_ELEVATED = 3'd2;
	localparam level_t LVL_HOT      = 3'd3;
	localparam level_t LVL_CRITICAL = 3'd4;

	// Debounce and reapply counts
	localparam cnt_t WARM_DEBOUNCE    = 4'd2;
	localparam cnt_t RELEASE_DEBOUNCE = 4'd10;
	localparam cnt_t REAPPLY_PERIOD   = 4'd10;
	localparam cnt_t CNT_MAX          = 4'd15;

	// Configuration register indexes
	localparam cfg_idx_t REG_WARM_ENTER    = 4'd0;
	localparam cfg_idx_t REG_WARM_RELEASE  = 4'd1;
	localparam cfg_idx_t REG_ELEV_ENTER    = 4'd2;
	localparam cfg_idx_t REG_ELEV_RELEASE  = 4'd3;
	localparam cfg_idx_t REG_HOT_ENTER     = 4'd4;
	localparam cfg_idx_t REG_HOT_RELEASE   = 4'd5;
	localparam cfg_idx_t REG_CRIT_ENTER    = 4'd6;
	localparam cfg_idx_t REG_CRIT_RELEASE  = 4'd7;

	// Threshold reset values, millidegrees
	localparam temp_t RST_WARM_ENTER   = 18'd78000;
	localparam temp_t RST_WARM_RELEASE = 18'd72000;
	localparam temp_t RST_ELEV_ENTER   = 18'd83000;
	localparam temp_t RST_ELEV_RELEASE = 18'd77000;
	localparam temp_t RST_HOT_ENTER    = 18'd90000;
	localparam temp_t RST_HOT_RELEASE  = 18'd84000;
	localparam temp_t RST_CRIT_ENTER   = 18'd97000;
	localparam temp_t RST_CRIT_RELEASE = 18'd90000;

	// Frequency caps by level
	localparam cap_t CAP_NORMAL   = 7'd100;
	localparam cap_t CAP_WARM     = 7'd80;
	localparam cap_t CAP_ELEVATED = 7'd70;
	localparam cap_t CAP_HOT      = 7'd55;
	localparam cap_t CAP_CRITICAL = 7'd35;

	typedef struct packed {
		temp_t warm_enter;
		temp_t warm_release;
		temp_t elev_enter;
		temp_t elev_release;
		temp_t hot_enter;
		temp_t hot_release;
		temp_t crit_enter;
		temp_t crit_release;
	} thresh_t;

	typedef struct packed {
		level_t level;
		cnt_t   warm_cnt;
		cnt_t   rel_cnt;
		cnt_t   reapply_cnt;
		temp_t  peak;
	} track_state_t;

	typedef struct packed {
		track_state_t nxt;
		logic         apply;
		logic         raised;
	} step_t;

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

	function automatic cap_t level_cap(level_t lvl);
		cap_t cap;
		unique case (lvl)
			LVL_NORMAL:   cap = CAP_NORMAL;
			LVL_WARM:     cap = CAP_WARM;
			LVL_ELEVATED: cap = CAP_ELEVATED;
			LVL_HOT:      cap = CAP_HOT;
			default:      cap = CAP_CRITICAL;
		endcase
		return cap;
	endfunction

endpackage

/* design/ttlt_cfg_regs.sv */
// Threshold register file written through the configuration port.
module ttlt_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  ttlt_pkg::cfg_idx_t wr_index,
	input  ttlt_pkg::temp_t    wr_data,
	output ttlt_pkg::thresh_t  thresh
);

	ttlt_pkg::thresh_t thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.warm_enter   <= ttlt_pkg::RST_WARM_ENTER;
			thresh_q.warm_release <= ttlt_pkg::RST_WARM_RELEASE;
			thresh_q.elev_enter   <= ttlt_pkg::RST_ELEV_ENTER;
			thresh_q.elev_release <= ttlt_pkg::RST_ELEV_RELEASE;
			thresh_q.hot_enter    <= ttlt_pkg::RST_HOT_ENTER;
			thresh_q.hot_release  <= ttlt_pkg::RST_HOT_RELEASE;
			thresh_q.crit_enter   <= ttlt_pkg::RST_CRIT_ENTER;
			thresh_q.crit_release <= ttlt_pkg::RST_CRIT_RELEASE;
		end else if (wr_en) begin
			unique case (wr_index)
				ttlt_pkg::REG_WARM_ENTER:   thresh_q.warm_enter   <= wr_data;
				ttlt_pkg::REG_WARM_RELEASE: thresh_q.warm_release <= wr_data;
				ttlt_pkg::REG_ELEV_ENTER:   thresh_q.elev_enter   <= wr_data;
				ttlt_pkg::REG_ELEV_RELEASE: thresh_q.elev_release <= wr_data;
				ttlt_pkg::REG_HOT_ENTER:    thresh_q.hot_enter    <= wr_data;
				ttlt_pkg::REG_HOT_RELEASE:  thresh_q.hot_release  <= wr_data;
				ttlt_pkg::REG_CRIT_ENTER:   thresh_q.crit_enter   <= wr_data;
				ttlt_pkg::REG_CRIT_RELEASE: thresh_q.crit_release <= wr_data;
				default: ;  // unmapped index: write is dropped
			endcase
		end
	end

	assign thresh = thresh_q;

endmodule

/* design/ttlt_level_step.sv */
// Next-state logic for one temperature sample: level, debounce, reapply and peak.
module ttlt_level_step (
	input  ttlt_pkg::track_state_t cur,
	input  ttlt_pkg::temp_t        temp,
	input  ttlt_pkg::thresh_t      thresh,
	output ttlt_pkg::step_t        step
);

	ttlt_pkg::level_t lvl_nxt;
	ttlt_pkg::cnt_t   warm_nxt;
	ttlt_pkg::cnt_t   rel_nxt;
	ttlt_pkg::cnt_t   warm_inc;
	ttlt_pkg::cnt_t   rel_inc;
	ttlt_pkg::cnt_t   reapply_inc;
	ttlt_pkg::temp_t  rel_level;
	logic             raised;
	logic             apply;

	assign warm_inc    = ttlt_pkg::sat_inc(cur.warm_cnt);
	assign rel_inc     = ttlt_pkg::sat_inc(cur.rel_cnt);
	assign reapply_inc = ttlt_pkg::sat_inc(cur.reapply_cnt);
	assign raised      = temp > cur.peak;

	always_comb begin
		unique case (cur.level)
			ttlt_pkg::LVL_WARM:     rel_level = thresh.warm_release;
			ttlt_pkg::LVL_ELEVATED: rel_level = thresh.elev_release;
			ttlt_pkg::LVL_HOT:      rel_level = thresh.hot_release;
			default:                rel_level = thresh.crit_release;
		endcase
	end

	// Escalation and release checks in priority order; the first match wins.
	always_comb begin
		lvl_nxt  = cur.level;
		warm_nxt = cur.warm_cnt;
		rel_nxt  = cur.rel_cnt;
		if (temp >= thresh.crit_enter) begin
			lvl_nxt  = ttlt_pkg::LVL_CRITICAL;
			warm_nxt = '0;
			rel_nxt  = '0;
		end else if (cur.level != ttlt_pkg::LVL_CRITICAL && temp >= thresh.hot_enter) begin
			lvl_nxt  = ttlt_pkg::LVL_HOT;
			warm_nxt = '0;
			rel_nxt  = '0;
		end else if ((cur.level == ttlt_pkg::LVL_NORMAL || cur.level == ttlt_pkg::LVL_WARM)
				&& temp >= thresh.elev_enter) begin
			lvl_nxt  = ttlt_pkg::LVL_ELEVATED;
			warm_nxt = '0;
			rel_nxt  = '0;
		end else if (cur.level == ttlt_pkg::LVL_NORMAL) begin
			if (temp >= thresh.warm_enter) begin
				if (warm_inc >= ttlt_pkg::WARM_DEBOUNCE) begin
					lvl_nxt  = ttlt_pkg::LVL_WARM;
					warm_nxt = '0;
				end else begin
					warm_nxt = warm_inc;
				end
			end else begin
				warm_nxt = '0;
			end
		end else if (temp < rel_level) begin
			if (rel_inc >= ttlt_pkg::RELEASE_DEBOUNCE) begin
				lvl_nxt = cur.level - ttlt_pkg::level_t'(1);
				rel_nxt = '0;
			end else begin
				rel_nxt = rel_inc;
			end
		end else begin
			rel_nxt = '0;
		end
	end

	// Periodic reapply only counts toward a flag while throttled.
	assign apply = (lvl_nxt != cur.level)
		|| (cur.level != ttlt_pkg::LVL_NORMAL && reapply_inc >= ttlt_pkg::REAPPLY_PERIOD);

	assign step.nxt.level       = lvl_nxt;
	assign step.nxt.warm_cnt    = warm_nxt;
	assign step.nxt.rel_cnt     = rel_nxt;
	assign step.nxt.reapply_cnt = apply ? '0 : reapply_inc;
	assign step.nxt.peak        = raised ? temp : cur.peak;
	assign step.apply           = apply;
	assign step.raised          = raised;

endmodule

/* design/thermal_throttle_level_tracker.sv */
// Thermal throttle level tracker: one throttle result for every temperature sample.
//
// Each accepted temperature sample yields exactly one result (level, cap_percent,
// apply_now, peak_temp, new_peak). A sample is taken in every cycle while results
// keep flowing. A sample waits in the input register; the level state and the
// result register load together when it leaves, and out_valid comes from the
// result register. The input stalls only while a sample sits in the input
// register behind a stalled result. Threshold writes on the configuration
// port are always ready and belong in idle periods only.
module thermal_throttle_level_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ttlt_pkg::temp_t    temperature,
	output logic               out_valid,
	input  logic               out_stall,
	output ttlt_pkg::level_t   level,
	output ttlt_pkg::cap_t     cap_percent,
	output logic               apply_now,
	output ttlt_pkg::temp_t    peak_temp,
	output logic               new_peak,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  ttlt_pkg::cfg_idx_t cfg_index,
	input  ttlt_pkg::temp_t    cfg_data
);

`include "thermal_throttle_level_tracker_macros.svh"

	ttlt_pkg::thresh_t      thresh;
	ttlt_pkg::track_state_t state_q;
	ttlt_pkg::step_t        step;

	logic              valid_s1;
	ttlt_pkg::temp_t   temp_s1;
	logic              valid_s2;
	ttlt_pkg::level_t  level_s2;
	logic              apply_s2;
	ttlt_pkg::temp_t   peak_s2;
	logic              raised_s2;
	logic              in_xfer;
	logic              adv_s1;

	assign cfg_ready = 1'b1;

	ttlt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.thresh   (thresh)
	);

	ttlt_level_step u_step (
		.cur    (state_q),
		.temp   (temp_s1),
		.thresh (thresh),
		.step   (step)
	);

	// Stage 1 moves on whenever the result register is free or being drained.
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			temp_s1 <= temperature;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= step.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			level_s2  <= step.nxt.level;
			apply_s2  <= step.apply;
			peak_s2   <= step.nxt.peak;
			raised_s2 <= step.raised;
		end
	end

	assign out_valid   = valid_s2;
	assign level       = level_s2;
	assign cap_percent = ttlt_pkg::level_cap(level_s2);
	assign apply_now   = apply_s2;
	assign peak_temp   = peak_s2;
	assign new_peak    = raised_s2;

	`TTLT_ASSERT_IMPL(a_level_range, 1'b1, state_q.level <= ttlt_pkg::LVL_CRITICAL)
	`TTLT_ASSERT_IMPL(a_change_applies, state_q.level != $past(state_q.level),
		valid_s2 && apply_s2 && level_s2 == state_q.level)
	`TTLT_ASSERT_NEXT(a_peak_monotonic, 1'b1, state_q.peak >= $past(state_q.peak))

endmodule

/* tb/sv/tb_thermal_throttle_level_tracker.sv */
// Self-checking testbench for the thermal throttle level tracker.
`timescale 1ns / 1ps

module tb_thermal_throttle_level_tracker;

	localparam int NUM_THRESH     = 8;
	localparam int LAST_CFG_INDEX = (1 << ttlt_pkg::CFG_IDX_W) - 1;
	localparam int TEMP_MAX       = (1 << ttlt_pkg::TEMP_W) - 1;
	localparam int LONG_HOLD      = 120;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int REPORT_LIMIT   = 40;

	typedef struct packed {
		ttlt_pkg::level_t level;
		ttlt_pkg::cap_t   cap;
		logic             apply;
		ttlt_pkg::temp_t  peak;
		logic             raised;
	} throttle_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	ttlt_pkg::temp_t    temperature = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	ttlt_pkg::level_t   level;
	ttlt_pkg::cap_t     cap_percent;
	logic               apply_now;
	ttlt_pkg::temp_t    peak_temp;
	logic               new_peak;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	ttlt_pkg::cfg_idx_t cfg_index = '0;
	ttlt_pkg::temp_t    cfg_data = '0;

	thermal_throttle_level_tracker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.temperature (temperature),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.level       (level),
		.cap_percent (cap_percent),
		.apply_now   (apply_now),
		.peak_temp   (peak_temp),
		.new_peak    (new_peak),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Tracker model state and threshold copy
	ttlt_pkg::temp_t  limits [NUM_THRESH];
	ttlt_pkg::temp_t  pending_limits [NUM_THRESH];
	ttlt_pkg::level_t trk_level = ttlt_pkg::LVL_NORMAL;
	ttlt_pkg::cnt_t   warm_run = '0;
	ttlt_pkg::cnt_t   release_run = '0;
	ttlt_pkg::cnt_t   reapply_run = '0;
	ttlt_pkg::temp_t  peak_seen = '0;

	throttle_result_t expected_results [$];
	ttlt_pkg::temp_t  row_temp [$];
	bit               row_typed [$];
	throttle_result_t row_want [$];

	bit idle_on = 1'b1;
	int hold_requests = 0;
	int hold_served = 0;
	int rx_wait = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int applies_seen = 0;

	function automatic throttle_result_t predict_throttle(ttlt_pkg::temp_t t);
		throttle_result_t r;
		ttlt_pkg::level_t nxt;
		ttlt_pkg::temp_t  rel;
		r.raised = (t > peak_seen);
		if (r.raised)
			peak_seen = t;

		if (t >= limits[ttlt_pkg::REG_CRIT_ENTER]) begin
			nxt = ttlt_pkg::LVL_CRITICAL;
			warm_run = '0;
			release_run = '0;
		end else if (trk_level != ttlt_pkg::LVL_CRITICAL
				&& t >= limits[ttlt_pkg::REG_HOT_ENTER]) begin
			nxt = ttlt_pkg::LVL_HOT;
			warm_run = '0;
			release_run = '0;
		end else if (trk_level <= ttlt_pkg::LVL_WARM
				&& t >= limits[ttlt_pkg::REG_ELEV_ENTER]) begin
			nxt = ttlt_pkg::LVL_ELEVATED;
			warm_run = '0;
			release_run = '0;
		end else if (trk_level == ttlt_pkg::LVL_NORMAL) begin
			nxt = ttlt_pkg::LVL_NORMAL;
			if (t >= limits[ttlt_pkg::REG_WARM_ENTER]) begin
				warm_run = (warm_run == ttlt_pkg::CNT_MAX) ? warm_run : warm_run + 1'b1;
				if (warm_run >= ttlt_pkg::WARM_DEBOUNCE) begin
					warm_run = '0;
					nxt = ttlt_pkg::LVL_WARM;
				end
			end else begin
				warm_run = '0;
			end
		end else begin
			case (trk_level)
				ttlt_pkg::LVL_WARM:     rel = limits[ttlt_pkg::REG_WARM_RELEASE];
				ttlt_pkg::LVL_ELEVATED: rel = limits[ttlt_pkg::REG_ELEV_RELEASE];
				ttlt_pkg::LVL_HOT:      rel = limits[ttlt_pkg::REG_HOT_RELEASE];
				default:                rel = limits[ttlt_pkg::REG_CRIT_RELEASE];
			endcase
			nxt = trk_level;
			if (t < rel) begin
				release_run = (release_run == ttlt_pkg::CNT_MAX) ? release_run
					: release_run + 1'b1;
				if (release_run >= ttlt_pkg::RELEASE_DEBOUNCE) begin
					release_run = '0;
					nxt = trk_level - 1'b1;
				end
			end else begin
				release_run = '0;
			end
		end

		reapply_run = (reapply_run == ttlt_pkg::CNT_MAX) ? reapply_run : reapply_run + 1'b1;
		r.apply = 1'b0;
		// periodic reapply looks at the level held before this sample
		if (nxt != trk_level || (trk_level != ttlt_pkg::LVL_NORMAL
				&& reapply_run >= ttlt_pkg::REAPPLY_PERIOD)) begin
			trk_level = nxt;
			reapply_run = '0;
			r.apply = 1'b1;
		end

		r.level = trk_level;
		case (trk_level)
			ttlt_pkg::LVL_NORMAL:   r.cap = ttlt_pkg::CAP_NORMAL;
			ttlt_pkg::LVL_WARM:     r.cap = ttlt_pkg::CAP_WARM;
			ttlt_pkg::LVL_ELEVATED: r.cap = ttlt_pkg::CAP_ELEVATED;
			ttlt_pkg::LVL_HOT:      r.cap = ttlt_pkg::CAP_HOT;
			default:                r.cap = ttlt_pkg::CAP_CRITICAL;
		endcase
		r.peak = peak_seen;
		return r;
	endfunction

	task automatic compare_field(string name, ttlt_pkg::temp_t want, ttlt_pkg::temp_t got);
		if (got !== want) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		throttle_result_t want;
		if (expected_results.size() == 0) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: result transfer with nothing expected, level %0d peak %0d",
					$time, level, peak_temp);
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			compare_field("level", ttlt_pkg::temp_t'(want.level), ttlt_pkg::temp_t'(level));
			compare_field("cap_percent", ttlt_pkg::temp_t'(want.cap),
				ttlt_pkg::temp_t'(cap_percent));
			compare_field("apply_now", ttlt_pkg::temp_t'(want.apply),
				ttlt_pkg::temp_t'(apply_now));
			compare_field("peak_temp", want.peak, peak_temp);
			compare_field("new_peak", ttlt_pkg::temp_t'(want.raised),
				ttlt_pkg::temp_t'(new_peak));
			results_checked++;
			if (apply_now === 1'b1)
				applies_seen++;
		end
	endtask

	// Result side: check each transfer, then draw the next stall length
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_result();
				rx_wait = idle_on ? $urandom_range(0, 3) : 0;
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				rx_wait = LONG_HOLD;
			end
			out_stall <= (rx_wait != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("tb_thermal_throttle_level_tracker failed");
				$finish;
			end
		end
	end

	task automatic send_sample(ttlt_pkg::temp_t t, bit typed, throttle_result_t typed_res);
		int gap;
		throttle_result_t predicted;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		temperature <= t;
		do @(posedge clk); while (in_stall);
		predicted = predict_throttle(t);
		expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
		samples_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(ttlt_pkg::cfg_idx_t idx, ttlt_pkg::temp_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_THRESH)
			limits[idx] = value;
		reg_writes++;
	endtask

	// Program all thresholds from pending_limits, plus one write to an unused index
	task automatic load_thresholds();
		drain();
		for (int i = 0; i < NUM_THRESH; i++)
			write_threshold(ttlt_pkg::cfg_idx_t'(i), pending_limits[i]);
		write_threshold(ttlt_pkg::cfg_idx_t'($urandom_range(NUM_THRESH, LAST_CFG_INDEX)),
			ttlt_pkg::temp_t'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Runs of samples held just above or just below a threshold, mixed with noise
	// and long cool-down runs so that releases chain down through the levels.
	task automatic run_random(int count);
		int              left;
		int              kind;
		int              run_len;
		int              spread;
		int              v;
		bit              above;
		ttlt_pkg::temp_t base;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				send_sample(ttlt_pkg::temp_t'($urandom), 1'b0, '0);
				left--;
			end else begin
				if (kind == 2) begin
					base = limits[ttlt_pkg::REG_WARM_RELEASE];
					above = 1'b0;
					run_len = $urandom_range(10, 30);
				end else begin
					base = limits[$urandom_range(0, NUM_THRESH - 1)];
					above = 1'($urandom_range(0, 1));
					run_len = $urandom_range(1, 14);
				end
				spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4000);
				repeat (run_len) begin
					if (left > 0) begin
						if (above)
							v = int'(base) + $urandom_range(0, spread);
						else
							v = int'(base) - 1 - $urandom_range(0, spread);
						if (v < 0)
							v = 0;
						if (v > TEMP_MAX)
							v = TEMP_MAX;
						send_sample(ttlt_pkg::temp_t'(v), 1'b0, '0);
						left--;
					end
				end
			end
		end
	endtask

	task automatic add_row(ttlt_pkg::temp_t t);
		row_temp.insert(row_temp.size(), t);
		row_typed.insert(row_typed.size(), 1'b0);
		row_want.insert(row_want.size(), '0);
	endtask

	task automatic add_checked(ttlt_pkg::temp_t t, ttlt_pkg::level_t lvl, ttlt_pkg::cap_t cap,
			logic apply, ttlt_pkg::temp_t peak, logic raised);
		throttle_result_t r;
		r.level = lvl;
		r.cap = cap;
		r.apply = apply;
		r.peak = peak;
		r.raised = raised;
		row_temp.insert(row_temp.size(), t);
		row_typed.insert(row_typed.size(), 1'b1);
		row_want.insert(row_want.size(), r);
	endtask

	initial begin
		int base;
		limits[ttlt_pkg::REG_WARM_ENTER]   = ttlt_pkg::RST_WARM_ENTER;
		limits[ttlt_pkg::REG_WARM_RELEASE] = ttlt_pkg::RST_WARM_RELEASE;
		limits[ttlt_pkg::REG_ELEV_ENTER]   = ttlt_pkg::RST_ELEV_ENTER;
		limits[ttlt_pkg::REG_ELEV_RELEASE] = ttlt_pkg::RST_ELEV_RELEASE;
		limits[ttlt_pkg::REG_HOT_ENTER]    = ttlt_pkg::RST_HOT_ENTER;
		limits[ttlt_pkg::REG_HOT_RELEASE]  = ttlt_pkg::RST_HOT_RELEASE;
		limits[ttlt_pkg::REG_CRIT_ENTER]   = ttlt_pkg::RST_CRIT_ENTER;
		limits[ttlt_pkg::REG_CRIT_RELEASE] = ttlt_pkg::RST_CRIT_RELEASE;

		// Directed walk on reset thresholds: zero sample, warm debounce, elevated
		// from warm, critical, full-scale sample, periodic reapply while critical,
		// step release down to hot, then a low sample and a jump back to critical.
		add_checked(18'd0,     ttlt_pkg::LVL_NORMAL,   ttlt_pkg::CAP_NORMAL,   1'b0,
			18'd0,     1'b0);
		add_checked(18'd50000, ttlt_pkg::LVL_NORMAL,   ttlt_pkg::CAP_NORMAL,   1'b0,
			18'd50000, 1'b1);
		add_checked(18'd78000, ttlt_pkg::LVL_NORMAL,   ttlt_pkg::CAP_NORMAL,   1'b0,
			18'd78000, 1'b1);
		add_checked(18'd78000, ttlt_pkg::LVL_WARM,     ttlt_pkg::CAP_WARM,     1'b1,
			18'd78000, 1'b0);
		add_checked(18'd83000, ttlt_pkg::LVL_ELEVATED, ttlt_pkg::CAP_ELEVATED, 1'b1,
			18'd83000, 1'b1);
		add_checked(18'd97000, ttlt_pkg::LVL_CRITICAL, ttlt_pkg::CAP_CRITICAL, 1'b1,
			18'd97000, 1'b1);
		add_checked(18'h3FFFF, ttlt_pkg::LVL_CRITICAL, ttlt_pkg::CAP_CRITICAL, 1'b0,
			18'h3FFFF, 1'b1);
		add_checked(18'd96999, ttlt_pkg::LVL_CRITICAL, ttlt_pkg::CAP_CRITICAL, 1'b0,
			18'h3FFFF, 1'b0);
		repeat (10) add_row(18'd89999);
		add_row(18'd90000);
		add_row(18'd83999);
		add_row(18'd1);
		add_row(18'd199999);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < row_temp.size(); i++)
			send_sample(row_temp[i], row_typed[i], row_want[i]);

		// ordered random thresholds
		base = $urandom_range(10000, 150000);
		pending_limits[ttlt_pkg::REG_WARM_ENTER]   = ttlt_pkg::temp_t'(base);
		pending_limits[ttlt_pkg::REG_WARM_RELEASE] =
			ttlt_pkg::temp_t'(base - $urandom_range(0, 8000));
		pending_limits[ttlt_pkg::REG_ELEV_ENTER]   =
			ttlt_pkg::temp_t'(base + $urandom_range(1, 8000));
		pending_limits[ttlt_pkg::REG_ELEV_RELEASE] =
			ttlt_pkg::temp_t'(pending_limits[ttlt_pkg::REG_ELEV_ENTER]
			- $urandom_range(0, 8000));
		pending_limits[ttlt_pkg::REG_HOT_ENTER]    =
			ttlt_pkg::temp_t'(pending_limits[ttlt_pkg::REG_ELEV_ENTER]
			+ $urandom_range(1, 8000));
		pending_limits[ttlt_pkg::REG_HOT_RELEASE]  =
			ttlt_pkg::temp_t'(pending_limits[ttlt_pkg::REG_HOT_ENTER]
			- $urandom_range(0, 8000));
		pending_limits[ttlt_pkg::REG_CRIT_ENTER]   =
			ttlt_pkg::temp_t'(pending_limits[ttlt_pkg::REG_HOT_ENTER]
			+ $urandom_range(1, 8000));
		pending_limits[ttlt_pkg::REG_CRIT_RELEASE] =
			ttlt_pkg::temp_t'(pending_limits[ttlt_pkg::REG_CRIT_ENTER]
			- $urandom_range(0, 8000));
		load_thresholds();
		run_random(300);

		// all thresholds at zero: pinned at critical, reapply only
		for (int i = 0; i < NUM_THRESH; i++)
			pending_limits[i] = '0;
		idle_on = 1'b0;
		load_thresholds();
		run_random(40);

		// all thresholds at full scale: only a full-scale sample escalates
		for (int i = 0; i < NUM_THRESH; i++)
			pending_limits[i] = ttlt_pkg::temp_t'(TEMP_MAX);
		idle_on = 1'b1;
		load_thresholds();
		run_random(40);

		// unordered random thresholds
		for (int i = 0; i < NUM_THRESH; i++)
			pending_limits[i] = ttlt_pkg::temp_t'($urandom_range(0, 199999));
		load_thresholds();
		run_random(150);

		// back to reset values, with a long output hold-off and a full pause
		pending_limits[ttlt_pkg::REG_WARM_ENTER]   = ttlt_pkg::RST_WARM_ENTER;
		pending_limits[ttlt_pkg::REG_WARM_RELEASE] = ttlt_pkg::RST_WARM_RELEASE;
		pending_limits[ttlt_pkg::REG_ELEV_ENTER]   = ttlt_pkg::RST_ELEV_ENTER;
		pending_limits[ttlt_pkg::REG_ELEV_RELEASE] = ttlt_pkg::RST_ELEV_RELEASE;
		pending_limits[ttlt_pkg::REG_HOT_ENTER]    = ttlt_pkg::RST_HOT_ENTER;
		pending_limits[ttlt_pkg::REG_HOT_RELEASE]  = ttlt_pkg::RST_HOT_RELEASE;
		pending_limits[ttlt_pkg::REG_CRIT_ENTER]   = ttlt_pkg::RST_CRIT_ENTER;
		pending_limits[ttlt_pkg::REG_CRIT_RELEASE] = ttlt_pkg::RST_CRIT_RELEASE;
		load_thresholds();
		run_random(100);
		idle_on = 1'b0;
		hold_requests++;
		run_random(100);
		drain();
		idle_on = 1'b1;
		run_random(200);

		drain();
		repeat (8) @(posedge clk);
		$display("run covered %0d samples over five threshold sets, %0d register writes;",
			samples_sent, reg_writes);
		$display("%0d results checked, %0d of them flagged for apply, %0d mismatches",
			results_checked, applies_seen, mismatches);
		if (mismatches == 0)
			$display("tb_thermal_throttle_level_tracker passed");
		else
			$display("tb_thermal_throttle_level_tracker failed");
		$finish;
	end

endmodule

/* thermal_throttle_level_tracker.f */
+incdir+design
design/ttlt_pkg.sv
design/ttlt_cfg_regs.sv
design/ttlt_level_step.sv
design/thermal_throttle_level_tracker.sv
tb/sv/tb_thermal_throttle_level_tracker.sv
